// File: rtl/core/ddc_pkg.sv
package ddc_pkg;

    // fixed field widths
    localparam int CountBits = 17;
    localparam int YearBits = 12;
    localparam int DayBits = 5;
    localparam int MonthBits = 4;
    localparam int DefaultBaseYear = 1978;

    localparam logic [CountBits-1:0] CountMax = '1;

    // month codes used in range checks
    localparam logic [MonthBits-1:0] MonthJan = 4'd1;
    localparam logic [MonthBits-1:0] MonthFeb = 4'd2;
    localparam logic [MonthBits-1:0] MonthDec = 4'd12;
    localparam logic [MonthBits-1:0] LastMonthIdx = 4'd11;

    typedef struct packed {
        logic                 mode;
        logic [CountBits-1:0] day_count_in;
        logic [DayBits-1:0]   day_in;
        logic [MonthBits-1:0] month_in;
        logic [YearBits-1:0]  year_in;
    } ddc_in_t;

    typedef struct packed {
        logic [DayBits-1:0]   day_of_month;
        logic [MonthBits-1:0] month_out;
        logic [YearBits-1:0]  year_out;
        logic [CountBits-1:0] day_count_out;
        logic                 invalid;
    } ddc_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } ddc_state_t;

    typedef struct packed {
        logic load;
        logic step_year;
        logic step_month;
        logic load_out;
    } ddc_cmd_t;

    typedef struct packed {
        logic mode;
        logic year_done;
        logic month_done;
    } ddc_status_t;

    // days in month, index 0 is january
    function automatic logic [DayBits-1:0] month_len(input logic [MonthBits-1:0] idx,
                                                     input logic leap);
        logic [DayBits-1:0] len;
        case (idx)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the first of the month in a common year, index 0 is january
    function automatic logic [8:0] month_start(input logic [MonthBits-1:0] idx);
        logic [8:0] start;
        case (idx)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd59;
            4'd3:    start = 9'd90;
            4'd4:    start = 9'd120;
            4'd5:    start = 9'd151;
            4'd6:    start = 9'd181;
            4'd7:    start = 9'd212;
            4'd8:    start = 9'd243;
            4'd9:    start = 9'd273;
            4'd10:   start = 9'd304;
            4'd11:   start = 9'd334;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

// File: rtl/core/ddc_ctrl.sv
module ddc_ctrl
    import ddc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  ddc_status_t status,
    output ddc_cmd_t    cmd
);

    ddc_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_YEAR;
            end
            ST_YEAR: begin
                if (status.year_done) state_next = status.mode ? ST_FINISH : ST_MONTH;
            end
            ST_MONTH: begin
                if (status.month_done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_YEAR: begin
                cmd.step_year = !status.year_done;
            end
            ST_MONTH: begin
                cmd.step_month = !status.month_done;
            end
            ST_FINISH: begin
                cmd.load_out = !out_valid_reg || m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // result beat valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    a_step_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.step_year && cmd.step_month))
        else $error("year and month step issued together");

    a_month_only_mode0: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MONTH |-> !status.mode)
        else $error("month walk entered for date to count");

    a_load_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> out_valid_reg)
        else $error("result load did not raise valid");

    a_finish_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_valid_reg && !m_ready) |=> state_reg == ST_FINISH)
        else $error("pending result overwritten");

endmodule

// File: rtl/core/ddc_dp.sv
module ddc_dp
    import ddc_pkg::*;
#(
    parameter int EPOCH_YEAR = DefaultBaseYear
) (
    input  logic        aclk,
    input  ddc_in_t     s_data,
    input  ddc_cmd_t    cmd,
    output ddc_status_t status,
    output ddc_out_t    m_data
);

    localparam int WorkBits = CountBits + 1;
    localparam int TotalBits = CountBits + 2;
    localparam logic [YearBits-1:0] BaseYear = YearBits'(EPOCH_YEAR);
    localparam logic [6:0] Base100 = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0] Base400 = 9'(EPOCH_YEAR % 400);

    ddc_in_t             in_reg, in_next;
    ddc_out_t            out_reg, out_next;
    logic [WorkBits-1:0] work_reg, work_next;
    logic [YearBits-1:0] year_reg, year_next;
    logic [6:0]          c100_reg, c100_next;
    logic [8:0]          c400_reg, c400_next;
    logic [MonthBits-1:0] mon_reg, mon_next;
    logic                ovf_reg, ovf_next;
    logic                bad_reg, bad_next;

    logic                leap;
    logic [8:0]          ylen;
    logic [DayBits-1:0]  mlen;
    logic [WorkBits-1:0] year_sum;
    logic [TotalBits-1:0] total;
    logic                month_adj;
    logic [MonthBits-1:0] month_idx;

    // leap rule from running year residues
    assign leap = (year_reg[1:0] == 2'd0) && (c100_reg != 7'd0 || c400_reg == 9'd0);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = month_len(mon_reg, leap);
    assign year_sum = work_reg + WorkBits'(ylen);

    // loop exit conditions
    always_comb begin
        status.mode = in_reg.mode;
        if (in_reg.mode) begin
            status.year_done = bad_reg || ovf_reg || (year_reg == in_reg.year_in);
        end else begin
            status.year_done = work_reg < WorkBits'(ylen);
        end
        status.month_done = (mon_reg == LastMonthIdx) || (work_reg < WorkBits'(mlen));
    end

    // final count for date to count
    assign month_idx = in_reg.month_in - MonthJan;
    assign month_adj = (in_reg.month_in > MonthFeb) && leap;
    assign total = TotalBits'(work_reg) + TotalBits'(month_start(month_idx))
                 + TotalBits'(month_adj) + TotalBits'(in_reg.day_in) - TotalBits'(1);

    // working registers
    always_comb begin
        in_next   = in_reg;
        work_next = work_reg;
        year_next = year_reg;
        c100_next = c100_reg;
        c400_next = c400_reg;
        mon_next  = mon_reg;
        ovf_next  = ovf_reg;
        bad_next  = bad_reg;
        if (cmd.load) begin
            in_next   = s_data;
            work_next = s_data.mode ? '0 : WorkBits'(s_data.day_count_in);
            year_next = BaseYear;
            c100_next = Base100;
            c400_next = Base400;
            mon_next  = '0;
            ovf_next  = 1'b0;
            bad_next  = s_data.mode && (s_data.month_in < MonthJan
                        || s_data.month_in > MonthDec || s_data.day_in == '0
                        || s_data.year_in < BaseYear);
        end else if (cmd.step_year) begin
            if (in_reg.mode) begin
                work_next = year_sum;
                ovf_next  = year_sum[WorkBits-1];
            end else begin
                work_next = work_reg - WorkBits'(ylen);
            end
            year_next = year_reg + YearBits'(1);
            c100_next = (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
            c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
        end else if (cmd.step_month) begin
            work_next = work_reg - WorkBits'(mlen);
            mon_next  = mon_reg + MonthBits'(1);
        end
    end

    // result assembly
    always_comb begin
        out_next = out_reg;
        if (cmd.load_out) begin
            out_next = '0;
            if (in_reg.mode) begin
                if (bad_reg) begin
                    out_next.invalid = 1'b1;
                end else if (ovf_reg || total > TotalBits'(CountMax)) begin
                    out_next.day_count_out = CountMax;
                    out_next.invalid       = 1'b1;
                end else begin
                    out_next.day_count_out = total[CountBits-1:0];
                end
            end else begin
                out_next.day_of_month = work_reg[DayBits-1:0] + DayBits'(1);
                out_next.month_out    = mon_reg + MonthBits'(1);
                out_next.year_out     = year_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_reg   <= in_next;
        out_reg  <= out_next;
        work_reg <= work_next;
        year_reg <= year_next;
        c100_reg <= c100_next;
        c400_reg <= c400_next;
        mon_reg  <= mon_next;
        ovf_reg  <= ovf_next;
        bad_reg  <= bad_next;
    end

    assign m_data = out_reg;

endmodule

// File: rtl/core/day_count_date_converter_unit.sv
// Gregorian day count / date converter.
// Input channel s_valid/s_ready/s_data carries one request beat; mode 0 turns
// day_count_in (days since 1 January of EPOCH_YEAR) into day, month and year,
// mode 1 turns day_in/month_in/year_in into a day count with an invalid flag.
// Result channel m_valid/m_ready/m_data returns exactly one beat per request.
// Walk: the datapath steps one year per cycle, then (mode 0) one month per
// cycle over 0..11 months. Mode 1 walks the years up to year_in, cut short
// once the count saturates and skipped for a bad date. One request is in
// work at a time; s_ready is high again the cycle after the result is loaded,
// so a new request is taken while the previous result still waits in the
// output register. When the receiver stalls, the next finished result waits
// inside the block until the output register frees up. Reset (aresetn low,
// synchronous) drops m_valid and returns the block to idle; no configuration
// is needed.
module day_count_date_converter_unit
    import ddc_pkg::*;
#(
    parameter int EPOCH_YEAR = DefaultBaseYear
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ddc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ddc_out_t m_data
);

    ddc_cmd_t    cmd;
    ddc_status_t status;

    // sequencer
    ddc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // year and month walk datapath
    ddc_dp #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_dp (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .status (status),
        .m_data (m_data)
    );

endmodule

// File: sim/tb_day_count_date_converter_unit.sv
module tb_day_count_date_converter_unit;
    import ddc_pkg::*;

    // direction select carried in the mode field
    localparam logic MODE_COUNT_TO_DATE = 1'b0;
    localparam logic MODE_DATE_TO_COUNT = 1'b1;

    localparam int unsigned RAND_ITEMS  = 1400;
    localparam int unsigned QUIET_TAIL  = 150;
    localparam int unsigned SETTLE_CYC  = 400;
    localparam int unsigned CYCLE_LIMIT = 4000000;

    localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30,
                                                   31, 31, 30, 31, 30, 31};
    localparam int unsigned DAYS_BEFORE_MONTH [12] = '{0, 31, 59, 90, 120, 151,
                                                       181, 212, 243, 273, 304, 334};

    typedef struct {
        ddc_in_t     beat;
        int unsigned gap;
        bit          drain_first;
    } pending_req_t;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ddc_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ddc_out_t m_data;

    pending_req_t req_q[$];
    ddc_out_t     expected_dates_q[$];

    int unsigned n_total;
    int unsigned n_sent    = 0;
    int unsigned n_seen    = 0;
    int unsigned n_err     = 0;
    int unsigned idle_cnt  = 0;
    int unsigned stall_cnt = 0;
    int unsigned cycle_cnt = 0;

    day_count_date_converter_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // gregorian leap rule
    function automatic bit is_leap(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_year(int unsigned y);
        return is_leap(y) ? 366 : 365;
    endfunction

    // days from 1 january of year 1 to 1 january of year y
    function automatic longint unsigned jan1_days(int unsigned y);
        longint unsigned p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    // expected result beat for one request beat
    function automatic ddc_out_t convert_date(ddc_in_t req);
        ddc_out_t        r;
        int unsigned     rem;
        int unsigned     yr;
        int unsigned     mi;
        int unsigned     mlen;
        int unsigned     d;
        int unsigned     m;
        longint unsigned total;
        r = '0;
        if (req.mode == MODE_COUNT_TO_DATE) begin
            rem = req.day_count_in;
            yr  = DefaultBaseYear;
            while (rem >= days_in_year(yr)) begin
                rem -= days_in_year(yr);
                yr++;
            end
            mi = 0;
            while (mi < LastMonthIdx) begin
                mlen = DAYS_IN_MONTH[mi] + ((mi == 1 && is_leap(yr)) ? 1 : 0);
                if (rem < mlen) break;
                rem -= mlen;
                mi++;
            end
            r.day_of_month = DayBits'(rem + 1);
            r.month_out    = MonthBits'(mi + 1);
            r.year_out     = YearBits'(yr);
        end else begin
            d  = req.day_in;
            m  = req.month_in;
            yr = req.year_in;
            if (m < MonthJan || m > MonthDec || d < 1) begin
                r.invalid = 1'b1;
            end else if (yr < DefaultBaseYear) begin
                r.invalid = 1'b1;
            end else begin
                total = jan1_days(yr) - jan1_days(DefaultBaseYear)
                        + DAYS_BEFORE_MONTH[m - 1] + d - 1;
                if (m > MonthFeb && is_leap(yr)) total += 1;
                if (total > CountMax) begin
                    total     = CountMax;
                    r.invalid = 1'b1;
                end
                r.day_count_out = CountBits'(total);
            end
        end
        return r;
    endfunction

    // request builders, unused fields get random junk
    function automatic ddc_in_t count_req(int unsigned cnt);
        ddc_in_t b;
        b.mode         = MODE_COUNT_TO_DATE;
        b.day_count_in = CountBits'(cnt);
        b.day_in       = DayBits'($urandom);
        b.month_in     = MonthBits'($urandom);
        b.year_in      = YearBits'($urandom);
        return b;
    endfunction

    function automatic ddc_in_t date_req(int unsigned d, int unsigned m, int unsigned y);
        ddc_in_t b;
        b.mode         = MODE_DATE_TO_COUNT;
        b.day_count_in = CountBits'($urandom);
        b.day_in       = DayBits'(d);
        b.month_in     = MonthBits'(m);
        b.year_in      = YearBits'(y);
        return b;
    endfunction

    task automatic add_req(ddc_in_t b, int unsigned gap, bit drain_first);
        pending_req_t p;
        p.beat        = b;
        p.gap         = gap;
        p.drain_first = drain_first;
        req_q.push_back(p);
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // driver: one request beat at a time from the pending queue
    always @(posedge aclk) begin : drv
        logic    nxt_valid;
        ddc_in_t nxt_data;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            idle_cnt = 0;
        end else begin
            nxt_valid = s_valid;
            nxt_data  = s_data;
            if (s_valid && s_ready) begin
                expected_dates_q.push_back(convert_date(s_data));
                n_sent    = n_sent + 1;
                nxt_valid = 1'b0;
            end
            // hold off for drain requests and idle gaps
            if (!nxt_valid && req_q.size() != 0) begin
                if (!(req_q[0].drain_first && n_sent != n_seen)) begin
                    if (idle_cnt < req_q[0].gap) begin
                        idle_cnt++;
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_data  = req_q[0].beat;
                        void'(req_q.pop_front());
                        idle_cnt = 0;
                    end
                end
            end
            s_valid <= nxt_valid;
            s_data  <= nxt_data;
        end
    end

    // monitor: random ready stalls and result checks
    always @(posedge aclk) begin : mon
        ddc_out_t exp_beat;
        logic     nxt_ready;
        bit       stalls_on;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (m_valid && m_ready) begin
                n_seen <= n_seen + 1;
                if (expected_dates_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result beat: dom=%0d mon=%0d yr=%0d cnt=%0d inv=%0b",
                                 m_data.day_of_month, m_data.month_out, m_data.year_out,
                                 m_data.day_count_out, m_data.invalid);
                end else begin
                    exp_beat = expected_dates_q.pop_front();
                    if (m_data.day_of_month !== exp_beat.day_of_month
                            || m_data.month_out !== exp_beat.month_out
                            || m_data.year_out !== exp_beat.year_out
                            || m_data.day_count_out !== exp_beat.day_count_out
                            || m_data.invalid !== exp_beat.invalid) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"result mismatch: exp dom=%0d mon=%0d yr=%0d cnt=%0d ",
                                      "inv=%0b, got dom=%0d mon=%0d yr=%0d cnt=%0d inv=%0b"},
                                     exp_beat.day_of_month, exp_beat.month_out,
                                     exp_beat.year_out, exp_beat.day_count_out,
                                     exp_beat.invalid, m_data.day_of_month,
                                     m_data.month_out, m_data.year_out,
                                     m_data.day_count_out, m_data.invalid);
                    end
                end
            end
            // stall windows, none near the end
            stalls_on = ((n_seen / 150) % 3 != 2) && (n_seen + QUIET_TAIL < n_total);
            if (stall_cnt > 0) begin
                stall_cnt--;
                nxt_ready = 1'b0;
            end else if (stalls_on && $urandom_range(0, 15) == 0) begin
                stall_cnt = $urandom_range(1, 14) - 1;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            m_ready <= nxt_ready;
        end
    end

    // timeout
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("tb_day_count_date_converter_unit: done, errors");
        $finish;
    end

    // stimulus and end of run
    initial begin : stim
        ddc_in_t     b;
        int unsigned pick;
        int unsigned yr;
        int unsigned gap;
        bit          quiet;

        // directed: range ends, leap rule, bad dates, saturation
        add_req(count_req(0), 0, 1'b0);
        add_req(count_req(364), 0, 1'b0);
        add_req(count_req(365), 3, 1'b0);
        add_req(count_req(789), 0, 1'b0);
        add_req(count_req(8094), 0, 1'b0);
        add_req(count_req(8095), 7, 1'b0);
        add_req(count_req(44617), 0, 1'b0);
        add_req(count_req(44618), 0, 1'b0);
        add_req(count_req(CountMax), 1, 1'b0);
        add_req(date_req(1, 1, DefaultBaseYear), 0, 1'b0);
        add_req(date_req(31, 12, 2335), 0, 1'b0);
        add_req(date_req(29, 2, 2000), 2, 1'b0);
        add_req(date_req(1, 3, 2000), 0, 1'b0);
        add_req(date_req(1, 3, 2100), 0, 1'b0);
        add_req(date_req(31, 4, 1999), 0, 1'b0);
        add_req(date_req(31, 2, 2100), 0, 1'b0);
        add_req(date_req(10, 0, 1990), 5, 1'b0);
        add_req(date_req(10, 13, 1990), 0, 1'b0);
        add_req(date_req(31, 15, 4095), 0, 1'b0);
        add_req(date_req(0, 6, 1990), 0, 1'b0);
        add_req(date_req(31, 12, 1977), 0, 1'b0);
        add_req(date_req(1, 1, 0), 0, 1'b0);
        add_req(date_req(1, 1, 2336), 0, 1'b0);
        add_req(date_req(31, 12, 2336), 0, 1'b0);
        add_req(date_req(31, 12, 4095), 0, 1'b0);

        // random part, mostly well-formed with small spans
        for (int i = 0; i < RAND_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 0) begin
                if (pick < 75)
                    b = count_req($urandom_range(0, 12000));
                else if (pick < 95)
                    b = count_req($urandom_range(0, CountMax));
                else
                    b = count_req($urandom_range(125000, CountMax));
            end else if (pick < 85) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)      yr = $urandom_range(DefaultBaseYear, 2010);
                else if (pick < 90) yr = $urandom_range(DefaultBaseYear, 2335);
                else if (pick < 95) yr = $urandom_range(2336, 4095);
                else                yr = $urandom_range(0, DefaultBaseYear - 1);
                b = date_req($urandom_range(1, 31), $urandom_range(1, 12), yr);
            end else begin
                // raw fields, often bad dates
                b = date_req($urandom_range(0, 31), $urandom_range(0, 15),
                             $urandom_range(0, 4095));
            end
            quiet = ((i / 100) % 4 == 3) || (i + QUIET_TAIL >= RAND_ITEMS);
            gap   = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
            add_req(b, gap, (i == 0) || (i % 400 == 200));
        end
        n_total = req_q.size();

        // reset
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for every request and result, then let the block settle
        while (req_q.size() != 0 || s_valid || n_seen != n_sent)
            @(negedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);

        if (n_err == 0 && expected_dates_q.size() == 0)
            $display("tb_day_count_date_converter_unit: done, clean");
        else
            $display("tb_day_count_date_converter_unit: done, errors");
        $finish;
    end

endmodule
